// ----- rtl/pbnm_pkg.sv -----
// Shared types, constants and helpers for the palette build and nearest match core.
package pbnm_pkg;

  // Channel, color and distance widths.
  localparam int CH_W   = 8;
  localparam int RGB_W  = 3 * CH_W;
  localparam int DIST_W = 10;

  // Largest Manhattan distance between two RGB888 colors; it never counts as a match.
  localparam logic [DIST_W-1:0] MAX_DIST = 10'(3 * 255);

  // Request kinds carried on the input tuser.
  localparam logic CMD_INSERT = 1'b0;
  localparam logic CMD_LOOKUP = 1'b1;

  // Result status carried on the output tuser.
  typedef enum logic [1:0] {
    ST_ADDED   = 2'd0,
    ST_PRESENT = 2'd1,
    ST_FULL    = 2'd2,
    ST_LOOKUP  = 2'd3
  } status_t;

  // Controller states.
  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_FLUSH,
    S_FINISH
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic issue;
    logic finish;
  } ctrl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic cnt_zero;
    logic addr_last;
    logic out_free;
  } ctrl_sts_t;

  // Absolute difference of two channel values.
  function automatic logic [CH_W-1:0] absdiff(input logic [CH_W-1:0] a,
                                              input logic [CH_W-1:0] b);
    return (a > b) ? (a - b) : (b - a);
  endfunction

endpackage

// ----- rtl/pbnm_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module pbnm_ram #(
  parameter int WIDTH  = 24,
  parameter int DEPTH  = 256,
  parameter int ADDR_W = 8
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- rtl/pbnm_ctrl.sv -----
// Controller state machine that sequences the palette scan for one request.
module pbnm_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  pbnm_pkg::ctrl_sts_t   sts,
  output pbnm_pkg::ctrl_cmd_t   ctl
);
  import pbnm_pkg::*;

  state_t state;
  state_t state_next;

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and command decode.
  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    ctl        = '0;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          ctl.load   = 1'b1;
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        // An empty palette has nothing to read.
        if (sts.cnt_zero) begin
          state_next = S_FINISH;
        end else begin
          ctl.issue = 1'b1;
          if (sts.addr_last) begin
            state_next = S_FLUSH;
          end
        end
      end
      S_FLUSH: begin
        // The last read word is compared during this cycle.
        state_next = S_FINISH;
      end
      S_FINISH: begin
        if (sts.out_free) begin
          ctl.finish = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

// ----- rtl/pbnm_dp.sv -----
// Datapath: palette memory, scan compare unit, entry count and output register.
module pbnm_dp #(
  parameter int DEPTH = 256,
  parameter int IDX_W = 8,
  parameter int CNT_W = 9
) (
  input  logic                  clk,
  input  logic                  rst,
  input  pbnm_pkg::ctrl_cmd_t   ctl,
  output pbnm_pkg::ctrl_sts_t   sts,
  input  logic [23:0]           in_data,
  input  logic                  in_user,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [23:0]           out_data,
  output logic [1:0]            out_user
);
  import pbnm_pkg::*;

  // Request registers.
  logic                item_cmd;
  logic [RGB_W-1:0]    item_rgb;

  // Scan address and read pipeline.
  logic [IDX_W-1:0]    addr;
  logic                rd_valid;
  logic [IDX_W-1:0]    rd_idx;
  logic [RGB_W-1:0]    rd_data;

  // Running results of the scan.
  logic [DIST_W-1:0]   best_dist;
  logic [IDX_W-1:0]    best_idx;
  logic                found;
  logic [IDX_W-1:0]    match_idx;

  // Palette fill level.
  logic [CNT_W-1:0]    count;
  logic [CNT_W-1:0]    count_next;
  logic [CNT_W-1:0]    cnt_m1;
  logic                is_full;

  // Output register.
  logic [7:0]          out_index;
  status_t             out_status;
  logic [8:0]          out_used;

  // Compare and finish logic.
  logic [DIST_W-1:0]   cur_dist;
  logic [IDX_W-1:0]    res_idx;
  status_t             res_status;
  logic                add_new;

  pbnm_ram #(
    .WIDTH  (RGB_W),
    .DEPTH  (DEPTH),
    .ADDR_W (IDX_W)
  ) u_ram (
    .clk   (clk),
    .we    (add_new),
    .waddr (count[IDX_W-1:0]),
    .wdata (item_rgb),
    .re    (ctl.issue),
    .raddr (addr),
    .rdata (rd_data)
  );

  // Manhattan distance of the word read in the last cycle.
  always_comb begin
    cur_dist = DIST_W'(absdiff(item_rgb[7:0],   rd_data[7:0]))
             + DIST_W'(absdiff(item_rgb[15:8],  rd_data[15:8]))
             + DIST_W'(absdiff(item_rgb[23:16], rd_data[23:16]));
  end

  // Status back to the controller.
  always_comb begin
    cnt_m1        = count - CNT_W'(1);
    is_full       = (count == CNT_W'(DEPTH));
    sts.cnt_zero  = (count == '0);
    sts.addr_last = (addr == cnt_m1[IDX_W-1:0]);
    sts.out_free  = !out_valid || out_ready;
  end

  // Result of the request once the scan is over.
  always_comb begin
    res_idx    = '0;
    res_status = ST_LOOKUP;
    add_new    = 1'b0;
    count_next = count;
    if (item_cmd == CMD_LOOKUP) begin
      res_idx    = best_idx;
      res_status = ST_LOOKUP;
    end else if (found) begin
      res_idx    = match_idx;
      res_status = ST_PRESENT;
    end else if (!is_full) begin
      res_idx    = count[IDX_W-1:0];
      res_status = ST_ADDED;
      add_new    = ctl.finish;
      count_next = count + CNT_W'(1);
    end else begin
      res_status = ST_FULL;
    end
  end

  // Request capture, scan address and running best and match.
  always_ff @(posedge clk) begin
    rd_idx <= addr;
    if (ctl.load) begin
      item_cmd  <= in_user;
      item_rgb  <= in_data;
      addr      <= '0;
      best_dist <= MAX_DIST;
      best_idx  <= '0;
      found     <= 1'b0;
      match_idx <= '0;
    end else begin
      if (ctl.issue) begin
        addr <= addr + IDX_W'(1);
      end
      if (rd_valid) begin
        if (cur_dist < best_dist) begin
          best_dist <= cur_dist;
          best_idx  <= rd_idx;
        end
        if (!found && (rd_data == item_rgb)) begin
          found     <= 1'b1;
          match_idx <= rd_idx;
        end
      end
    end
  end

  // Read pipeline valid and palette fill level.
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_valid <= 1'b0;
      count    <= '0;
    end else begin
      rd_valid <= ctl.issue;
      if (ctl.finish) begin
        count <= count_next;
      end
    end
  end

  // Output register valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctl.finish) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // Output register payload.
  always_ff @(posedge clk) begin
    if (ctl.finish) begin
      out_index  <= 8'(res_idx);
      out_status <= res_status;
      out_used   <= 9'(count_next);
    end
  end

  assign out_data = {7'b0, out_used, out_index};
  assign out_user = out_status;

endmodule

// ----- rtl/palette_build_and_nearest_match_core.sv -----
// After a request is accepted, the scan reads each palette entry in use (none for an
// empty palette), one entry per cycle through the single memory read port; the last
// word is compared in the flush state, and the result is registered in the finish state
// once the output is free; no new request is taken before the controller is idle again.
// Reset (rst, synchronous): empties the palette count, returns the controller to idle
// and drops any pending result; the palette memory itself is not cleared.
module palette_build_and_nearest_match_core #(
  parameter int PALETTE_DEPTH = 256
) (
  input  logic        clk,
  input  logic        rst,
  // Request channel.
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // [7:0] red, [15:8] green, [23:16] blue
  input  logic        s_axis_tuser,   // [0] cmd
  // Result channel.
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // [7:0] color_index, [16:8] entries_used, [23:17] zero
  output logic [1:0]  m_axis_tuser    // [1:0] insert_status
);
  import pbnm_pkg::*;

  localparam int IDX_W = (PALETTE_DEPTH > 1) ? $clog2(PALETTE_DEPTH) : 1;
  localparam int CNT_W = $clog2(PALETTE_DEPTH + 1);

  ctrl_cmd_t ctl;
  ctrl_sts_t sts;

  pbnm_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .sts      (sts),
    .ctl      (ctl)
  );

  pbnm_dp #(
    .DEPTH (PALETTE_DEPTH),
    .IDX_W (IDX_W),
    .CNT_W (CNT_W)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .ctl       (ctl),
    .sts       (sts),
    .in_data   (s_axis_tdata),
    .in_user   (s_axis_tuser),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_data  (m_axis_tdata),
    .out_user  (m_axis_tuser)
  );

endmodule

// ----- rtl/pbnm_chk.sv -----
// Port-level checker for the palette build and nearest match core, with its bind.
module pbnm_chk (
  input logic        clk,
  input logic        rst,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [23:0] m_axis_tdata,
  input logic [1:0]  m_axis_tuser
);
  import pbnm_pkg::*;

  // Reset drops any pending result.
  a_rst_clears: assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("result valid after reset");

  // A stalled result holds its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("stalled result changed");

  // Requests are processed one at a time: no request directly after another.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("request taken while busy");

  // A new result only appears at the end of a scan, never out of idle.
  a_result_from_scan: assert property (@(posedge clk) disable iff (rst)
    $rose(m_axis_tvalid) |-> !$past(s_axis_tready))
    else $error("result appeared without a scan");

  // A dropped insert reports index zero.
  a_full_index: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && (m_axis_tuser == ST_FULL) |-> (m_axis_tdata[7:0] == 8'd0))
    else $error("full status with nonzero index");

endmodule

bind palette_build_and_nearest_match_core pbnm_chk u_pbnm_chk (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);
